// File: sv/tcd_pkg.sv
// ----------------------------------------------------------------------------
// TCP header change detector package
// Shared types, register indexes and helper functions.
// ----------------------------------------------------------------------------
package tcd_pkg;

    localparam logic [15:0] HDR_BYTES = 16'd40;
    localparam logic [15:0] SEQ_LAST  = 16'hfffe;

    localparam logic [7:0] CFG_REPEAT_LIMIT = 8'd0;
    localparam logic [7:0] CFG_MAX_DELTA    = 8'd1;

    localparam logic [3:0] REPEAT_LIMIT_RESET = 4'd3;
    localparam logic [7:0] MAX_DELTA_RESET    = 8'd20;

    typedef enum logic [1:0] {
        ID_SEQUENTIAL = 2'd0,
        ID_SWAPPED    = 2'd1,
        ID_ZERO       = 2'd2,
        ID_RANDOM     = 2'd3
    } t_ident_behavior;

    typedef struct packed {
        logic [15:0] packet_length;
        logic [15:0] ip_ident;
        logic [1:0]  ip_ecn;
        logic [1:0]  tcp_ecn_flags;
        logic [3:0]  tcp_reserved;
    } t_in_item;

    typedef struct packed {
        logic            ecn_in_use;
        logic            ecn_use_changed;
        t_ident_behavior ident_behavior;
        logic [15:0]     payload_length;
        logic [15:0]     sequence_number;
    } t_out_item;

    typedef struct packed {
        logic [3:0] repeat_limit;
        logic [7:0] max_delta;
    } t_cfg;

    function automatic logic [15:0] swap_bytes(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    // The increasing window is counted modulo 0xffff.
    function automatic logic ident_increasing(input logic [15:0] prev,
                                              input logic [15:0] cur,
                                              input logic [7:0]  d);
        logic [15:0] diff;
        logic [16:0] sum;
        logic [15:0] lim;
        logic        direct;
        logic        wrap;
        diff   = cur - prev;
        direct = (cur > prev) && (diff < {8'd0, d});
        sum    = {1'b0, prev} + {9'd0, d};
        wrap   = sum > 17'h0ffff;
        lim    = 16'(sum - 17'h0ffff);
        return direct || (wrap && ((cur > prev) || (cur < lim)));
    endfunction

endpackage

// File: sv/tcd_if.sv
// ----------------------------------------------------------------------------
// TCP header change detector channels
// Packet, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tcd_in_if;
    logic              valid;
    logic              ready;
    tcd_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcd_out_if;
    logic               valid;
    logic               ready;
    tcd_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/tcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// TCP header change detector configuration registers
// Holds the repeat limit and the IP-ID delta window.
// ----------------------------------------------------------------------------
module tcd_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcd_cfg_if.sink       i_cfg,
    output tcd_pkg::t_cfg o_cfg
);

    logic [3:0] r_repeat_limit;
    logic [7:0] r_max_delta;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_limit <= tcd_pkg::REPEAT_LIMIT_RESET;
            r_max_delta    <= tcd_pkg::MAX_DELTA_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tcd_pkg::CFG_REPEAT_LIMIT: r_repeat_limit <= i_cfg.data[3:0];
                tcd_pkg::CFG_MAX_DELTA:    r_max_delta    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.repeat_limit = r_repeat_limit;
    assign o_cfg.max_delta    = r_max_delta;

endmodule

// File: sv/tcd_ident_classifier.sv
// ----------------------------------------------------------------------------
// TCP header change detector IP-ID classifier
// Classifies the step from the previous IP-ID to the current one.
// ----------------------------------------------------------------------------
module tcd_ident_classifier (
    input  logic [15:0]               i_prev,
    input  logic [15:0]               i_cur,
    input  logic [7:0]                i_max_delta,
    output tcd_pkg::t_ident_behavior  o_behavior
);

    logic inc_plain;
    logic inc_swapped;

    assign inc_plain   = tcd_pkg::ident_increasing(i_prev, i_cur, i_max_delta);
    assign inc_swapped = tcd_pkg::ident_increasing(tcd_pkg::swap_bytes(i_prev),
                                                   tcd_pkg::swap_bytes(i_cur),
                                                   i_max_delta);

    always_comb begin
        if (inc_plain) begin
            o_behavior = tcd_pkg::ID_SEQUENTIAL;
        end else if (inc_swapped) begin
            o_behavior = tcd_pkg::ID_SWAPPED;
        end else if (i_cur == 16'd0) begin
            o_behavior = tcd_pkg::ID_ZERO;
        end else begin
            o_behavior = tcd_pkg::ID_RANDOM;
        end
    end

endmodule

// File: sv/tcp_header_change_detector_unit.sv
// ----------------------------------------------------------------------------
// TCP header change detector
// Per-packet ECN-used tracking, IP-ID classification, payload length and
// master sequence number for one TCP/IPv4 flow.
// ----------------------------------------------------------------------------
// Usage: packet header fields arrive on i_in and one result per packet leaves
// on o_out; both are valid/ready channels and a transaction completes when
// valid and ready are high at a rising edge. i_cfg writes register 0 (repeat
// limit) or register 1 (IP-ID delta window); it is always ready and should be
// written only while no packet is in flight.
// A packet is captured in the input register; once the output register is free,
// its result is computed and loaded into the output register together with the
// flow state, and is offered on o_out from there. One packet per cycle is
// sustained while o_out takes every result, limited by the single
// compare-and-update stage.
// When o_out stalls, the result register holds and the input register keeps
// one further packet; i_in then drops ready until the result is taken.
// Reset restores the register defaults and clears all flow state, so the
// first packet afterwards is classified as sequential.
// ----------------------------------------------------------------------------
module tcp_header_change_detector_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcd_in_if.sink    i_in,
    tcd_out_if.source o_out,
    tcd_cfg_if.sink   i_cfg
);

    tcd_pkg::t_cfg cfg;

    logic              r_s1_valid;
    tcd_pkg::t_in_item r_s1;
    logic              r_out_valid;
    tcd_pkg::t_out_item r_out;

    logic            r_ecn_used;
    logic [3:0]      r_repeat_count;
    logic [3:0]      r_zero_wait;
    logic [3:0]      r_last_reserved;
    logic [15:0]     r_last_ident;
    logic            r_first_seen;
    logic [15:0]     r_seq;

    logic            s2_ready;
    logic            s2_load;
    logic            ecn_nz;
    logic            res_changed;
    logic            by_res;
    logic            by_unset;
    logic            by_set;
    logic            n_changed;
    logic            n_ecn_used;
    logic [3:0]      n_repeat_count;
    logic [3:0]      n_zero_wait;
    logic [15:0]     n_seq;
    logic [15:0]     n_payload;
    tcd_pkg::t_ident_behavior classified;
    tcd_pkg::t_ident_behavior n_behavior;

    tcd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tcd_ident_classifier u_ident (
        .i_prev      (r_last_ident),
        .i_cur       (r_s1.ip_ident),
        .i_max_delta (cfg.max_delta),
        .o_behavior  (classified)
    );

    assign s2_ready   = !r_out_valid || o_out.ready;
    assign s2_load    = r_s1_valid && s2_ready;
    assign i_in.ready = !r_s1_valid || s2_ready;

    assign ecn_nz      = |(r_s1.ip_ecn | r_s1.tcp_ecn_flags);
    assign res_changed = r_s1.tcp_reserved != r_last_reserved;
    assign by_res      = res_changed && !r_ecn_used;
    assign by_unset    = !ecn_nz && r_ecn_used;
    assign by_set      = ecn_nz && !r_ecn_used;

    always_comb begin
        n_changed      = 1'b0;
        n_ecn_used     = r_ecn_used;
        n_repeat_count = r_repeat_count;
        n_zero_wait    = 4'd0;
        if (by_res || by_unset || by_set) begin
            if (by_unset && (r_zero_wait < cfg.repeat_limit)) begin
                n_zero_wait = r_zero_wait + 4'd1;
            end else begin
                n_changed      = 1'b1;
                n_ecn_used     = ecn_nz || res_changed;
                n_repeat_count = 4'd0;
            end
        end else if (r_repeat_count < cfg.repeat_limit) begin
            n_changed      = 1'b1;
            n_repeat_count = r_repeat_count + 4'd1;
        end
    end

    assign n_behavior = r_first_seen ? classified : tcd_pkg::ID_SEQUENTIAL;
    assign n_seq      = (r_seq == tcd_pkg::SEQ_LAST) ? 16'd0 : r_seq + 16'd1;
    assign n_payload  = (r_s1.packet_length < tcd_pkg::HDR_BYTES) ? 16'd0
                        : r_s1.packet_length - tcd_pkg::HDR_BYTES;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_ecn_used      <= 1'b0;
            r_repeat_count  <= 4'd0;
            r_zero_wait     <= 4'd0;
            r_last_reserved <= 4'd0;
            r_last_ident    <= 16'd0;
            r_first_seen    <= 1'b0;
            r_seq           <= 16'd0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_out_valid     <= 1'b1;
                r_ecn_used      <= n_ecn_used;
                r_repeat_count  <= n_repeat_count;
                r_zero_wait     <= n_zero_wait;
                r_last_reserved <= r_s1.tcp_reserved;
                r_last_ident    <= r_s1.ip_ident;
                r_first_seen    <= 1'b1;
                r_seq           <= n_seq;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1 <= i_in.data;
        end
        if (s2_load) begin
            r_out.ecn_in_use      <= n_ecn_used;
            r_out.ecn_use_changed <= n_changed;
            r_out.ident_behavior  <= n_behavior;
            r_out.payload_length  <= n_payload;
            r_out.sequence_number <= n_seq;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_load_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_load |=> o_out.valid)
        else $error("loaded result is not offered");

    a_first_sequential: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_load && !r_first_seen |=> o_out.data.ident_behavior == tcd_pkg::ID_SEQUENTIAL)
        else $error("first packet not classified as sequential");

    a_seq_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_load |=> o_out.data.sequence_number == r_seq)
        else $error("sequence number out of step with counter");

    a_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq != 16'hffff)
        else $error("sequence counter reached 0xffff");

endmodule

// File: dv/tb_tcp_header_change_detector_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TCP header change detector testbench
// Drives packet header transactions through the detector, with a short
// directed sequence followed by random flows under several register settings,
// and checks every result against a cycle-free model of the flow state.
// ----------------------------------------------------------------------------
module tb_tcp_header_change_detector_unit;

    localparam int unsigned NUM_SETTINGS = 8;
    localparam int unsigned PKTS_PER_SETTING = 150;

    logic i_clk;
    logic i_rst_n;

    tcd_in_if  pkt_if();
    tcd_out_if res_if();
    tcd_cfg_if cfg_if();

    tcp_header_change_detector_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pkt_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    int unsigned limit_plan [NUM_SETTINGS] = '{3, 0, 15, 1, 7, 0, 15, 2};
    int unsigned delta_plan [NUM_SETTINGS] = '{20, 0, 255, 1, 64, 255, 0, 20};

    tcd_pkg::t_in_item  packets_to_send[$];
    tcd_pkg::t_out_item expected_results[$];

    int unsigned send_gap_pct;
    int unsigned take_gap_pct;
    int unsigned error_count;
    int unsigned results_checked;
    int unsigned resent_count;
    int unsigned random_id_count;

    logic [3:0]  cur_repeat_limit;
    logic [7:0]  cur_max_delta;
    logic        ecn_state;
    logic [3:0]  repeat_cnt;
    logic [3:0]  clear_wait_cnt;
    logic [3:0]  prev_reserved;
    logic [15:0] prev_ident;
    logic [15:0] seq_num;
    logic        seen_any;

    tcd_pkg::t_ident_behavior gen_mode;
    logic [15:0]              gen_ident;
    logic [15:0]              gen_swapped;
    logic                     gen_ecn_on;
    logic [3:0]               gen_res;

    always #2 i_clk = ~i_clk;

    function automatic logic in_window(input logic [15:0] prev, input logic [15:0] cur);
        int d;
        int p;
        int c;
        d = int'(cur_max_delta);
        p = int'(prev);
        c = int'(cur);
        if (c > p && c - p < d) begin
            return 1'b1;
        end
        return (p > 65535 - d) && (c > p || c < d - (65535 - p));
    endfunction

    function automatic tcd_pkg::t_ident_behavior classify_ident_step(
        input logic [15:0] prev, input logic [15:0] cur);
        if (in_window(prev, cur)) begin
            return tcd_pkg::ID_SEQUENTIAL;
        end
        if (in_window({prev[7:0], prev[15:8]}, {cur[7:0], cur[15:8]})) begin
            return tcd_pkg::ID_SWAPPED;
        end
        if (cur == 16'd0) begin
            return tcd_pkg::ID_ZERO;
        end
        return tcd_pkg::ID_RANDOM;
    endfunction

    function automatic tcd_pkg::t_out_item detect_changes(input tcd_pkg::t_in_item p);
        tcd_pkg::t_out_item r;
        logic               ecn_any;
        logic               res_diff;
        logic               by_res;
        logic               by_clear;
        logic               by_set;
        ecn_any  = |(p.ip_ecn | p.tcp_ecn_flags);
        res_diff = (p.tcp_reserved != prev_reserved);
        by_res   = res_diff && !ecn_state;
        by_clear = !ecn_any && ecn_state;
        by_set   = ecn_any && !ecn_state;
        if (by_res || by_clear || by_set) begin
            if (by_clear && clear_wait_cnt < cur_repeat_limit) begin
                r.ecn_use_changed = 1'b0;
                clear_wait_cnt = clear_wait_cnt + 4'd1;
            end else begin
                r.ecn_use_changed = 1'b1;
                ecn_state = ecn_any || res_diff;
                repeat_cnt = 4'd0;
                clear_wait_cnt = 4'd0;
            end
        end else if (repeat_cnt < cur_repeat_limit) begin
            r.ecn_use_changed = 1'b1;
            repeat_cnt = repeat_cnt + 4'd1;
            clear_wait_cnt = 4'd0;
        end else begin
            r.ecn_use_changed = 1'b0;
            clear_wait_cnt = 4'd0;
        end
        r.ident_behavior = seen_any ? classify_ident_step(prev_ident, p.ip_ident)
                                    : tcd_pkg::ID_SEQUENTIAL;
        prev_ident = p.ip_ident;
        prev_reserved = p.tcp_reserved;
        seen_any = 1'b1;
        seq_num = (seq_num == tcd_pkg::SEQ_LAST) ? 16'd0 : seq_num + 16'd1;
        r.ecn_in_use = ecn_state;
        r.payload_length = (p.packet_length < tcd_pkg::HDR_BYTES) ? 16'd0
                           : p.packet_length - tcd_pkg::HDR_BYTES;
        r.sequence_number = seq_num;
        return r;
    endfunction

    function automatic tcd_pkg::t_in_item make_packet(input logic [15:0] len,
                                                      input logic [15:0] id,
                                                      input logic [1:0] ip_ecn,
                                                      input logic [1:0] tcp_ecn,
                                                      input logic [3:0] res);
        tcd_pkg::t_in_item p;
        p.packet_length = len;
        p.ip_ident = id;
        p.ip_ecn = ip_ecn;
        p.tcp_ecn_flags = tcp_ecn;
        p.tcp_reserved = res;
        return p;
    endfunction

    function automatic tcd_pkg::t_in_item random_packet();
        tcd_pkg::t_in_item p;
        int unsigned       roll;
        int unsigned       step;
        if ($urandom_range(99) < 8) begin
            p.packet_length = 16'($urandom_range(65535));
            p.ip_ident = 16'($urandom_range(65535));
            p.ip_ecn = 2'($urandom_range(3));
            p.tcp_ecn_flags = 2'($urandom_range(3));
            p.tcp_reserved = 4'($urandom_range(15));
            return p;
        end
        if ($urandom_range(99) < 5) begin
            gen_mode = tcd_pkg::t_ident_behavior'($urandom_range(3));
        end
        if ($urandom_range(99) < 4) begin
            gen_ident = 16'hffff - 16'($urandom_range(30));
            gen_swapped = 16'hffff - 16'($urandom_range(30));
        end
        step = ($urandom_range(9) < 7) ? $urandom_range(1, 8) : $urandom_range(1, 300);
        case (gen_mode)
            tcd_pkg::ID_SEQUENTIAL: begin
                gen_ident = gen_ident + 16'(step);
                p.ip_ident = gen_ident;
            end
            tcd_pkg::ID_SWAPPED: begin
                gen_swapped = gen_swapped + 16'(step);
                p.ip_ident = {gen_swapped[7:0], gen_swapped[15:8]};
            end
            tcd_pkg::ID_ZERO: begin
                p.ip_ident = 16'd0;
            end
            default: begin
                p.ip_ident = 16'($urandom_range(65535));
            end
        endcase
        if ($urandom_range(99) < 10) begin
            gen_ecn_on = !gen_ecn_on;
        end
        if (gen_ecn_on) begin
            p.ip_ecn = 2'($urandom_range(3));
            p.tcp_ecn_flags = 2'($urandom_range(3));
            if (p.ip_ecn == 2'd0 && p.tcp_ecn_flags == 2'd0) begin
                p.ip_ecn = 2'($urandom_range(1, 3));
            end
        end else begin
            p.ip_ecn = 2'd0;
            p.tcp_ecn_flags = 2'd0;
        end
        if ($urandom_range(99) < 6) begin
            gen_res = 4'($urandom_range(15));
        end
        p.tcp_reserved = gen_res;
        roll = $urandom_range(99);
        if (roll < 20) begin
            p.packet_length = 16'($urandom_range(45));
        end else if (roll < 25) begin
            p.packet_length = 16'($urandom_range(65500, 65535));
        end else if (roll < 35) begin
            p.packet_length = 16'($urandom_range(65535));
        end else begin
            p.packet_length = 16'($urandom_range(40, 1500));
        end
        return p;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_result(input tcd_pkg::t_out_item got);
        tcd_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            report_error("result transaction with no packet outstanding");
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (want.ecn_use_changed) begin
            resent_count++;
        end
        if (want.ident_behavior == tcd_pkg::ID_RANDOM) begin
            random_id_count++;
        end
        if (got.ecn_in_use !== want.ecn_in_use) begin
            report_error($sformatf("ecn_in_use %b, expected %b",
                                   got.ecn_in_use, want.ecn_in_use));
        end
        if (got.ecn_use_changed !== want.ecn_use_changed) begin
            report_error($sformatf("ecn_use_changed %b, expected %b",
                                   got.ecn_use_changed, want.ecn_use_changed));
        end
        if (got.ident_behavior !== want.ident_behavior) begin
            report_error($sformatf("ident_behavior %0d, expected %0d",
                                   got.ident_behavior, want.ident_behavior));
        end
        if (got.payload_length !== want.payload_length) begin
            report_error($sformatf("payload_length %0d, expected %0d",
                                   got.payload_length, want.payload_length));
        end
        if (got.sequence_number !== want.sequence_number) begin
            report_error($sformatf("sequence_number %0d, expected %0d",
                                   got.sequence_number, want.sequence_number));
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == tcd_pkg::CFG_REPEAT_LIMIT) begin
            cur_repeat_limit = val[3:0];
        end else if (idx == tcd_pkg::CFG_MAX_DELTA) begin
            cur_max_delta = val;
        end
    endtask

    task automatic wait_drained();
        while (packets_to_send.size() != 0 || expected_results.size() != 0
               || pkt_if.valid) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pkt_if.valid <= 1'b0;
        end else begin
            if (pkt_if.valid && pkt_if.ready) begin
                expected_results.push_back(detect_changes(pkt_if.data));
            end
            if (!pkt_if.valid || pkt_if.ready) begin
                if (packets_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    pkt_if.valid <= 1'b1;
                    pkt_if.data <= packets_to_send.pop_front();
                end else begin
                    pkt_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= take_gap_pct);
            if (res_if.valid && res_if.ready) begin
                check_result(res_if.data);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int unsigned ph;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        pkt_if.valid = 1'b0;
        pkt_if.data = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        send_gap_pct = 8;
        take_gap_pct = 69;
        error_count = 0;
        results_checked = 0;
        resent_count = 0;
        random_id_count = 0;
        cur_repeat_limit = tcd_pkg::REPEAT_LIMIT_RESET;
        cur_max_delta = tcd_pkg::MAX_DELTA_RESET;
        ecn_state = 1'b0;
        repeat_cnt = 4'd0;
        clear_wait_cnt = 4'd0;
        prev_reserved = 4'd0;
        prev_ident = 16'd0;
        seq_num = 16'd0;
        seen_any = 1'b0;
        gen_mode = tcd_pkg::ID_SEQUENTIAL;
        gen_ident = 16'h1000;
        gen_swapped = 16'h0100;
        gen_ecn_on = 1'b0;
        gen_res = 4'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First packet, short lengths, IP-ID steps across the 0xffff window edge, ECN on/off and reserved-bit changes.
        packets_to_send.push_back(make_packet(16'd0, 16'h1234, 2'd0, 2'd0, 4'd0));
        packets_to_send.push_back(make_packet(16'd39, 16'h1235, 2'd0, 2'd0, 4'd0));
        packets_to_send.push_back(make_packet(16'd40, 16'h1249, 2'd0, 2'd0, 4'd0));
        packets_to_send.push_back(make_packet(16'd41, 16'h124a, 2'd0, 2'd0, 4'd0));
        packets_to_send.push_back(make_packet(16'hffff, 16'h0000, 2'd0, 2'd0, 4'd0));
        packets_to_send.push_back(make_packet(16'd1500, 16'h0100, 2'd0, 2'd0, 4'd0));
        packets_to_send.push_back(make_packet(16'd60, 16'hfffe, 2'd0, 2'd0, 4'd0));
        packets_to_send.push_back(make_packet(16'd60, 16'h0003, 2'd0, 2'd0, 4'd0));
        packets_to_send.push_back(make_packet(16'd60, 16'hffff, 2'd0, 2'd0, 4'd0));
        packets_to_send.push_back(make_packet(16'd60, 16'h0005, 2'd0, 2'd0, 4'd0));
        packets_to_send.push_back(make_packet(16'd100, 16'h0006, 2'd3, 2'd0, 4'd0));
        packets_to_send.push_back(make_packet(16'd100, 16'h0007, 2'd0, 2'd3, 4'd0));
        packets_to_send.push_back(make_packet(16'd100, 16'h0008, 2'd1, 2'd2, 4'd0));
        for (int i = 0; i < 5; i++) begin
            packets_to_send.push_back(make_packet(16'd100, 16'(9 + i), 2'd0, 2'd0, 4'd0));
        end
        packets_to_send.push_back(make_packet(16'd100, 16'h0010, 2'd0, 2'd0, 4'hf));
        packets_to_send.push_back(make_packet(16'd100, 16'h0011, 2'd0, 2'd0, 4'hf));
        packets_to_send.push_back(make_packet(16'd100, 16'h0012, 2'd0, 2'd0, 4'h0));
        packets_to_send.push_back(make_packet(16'hffff, 16'hffff, 2'd3, 2'd3, 4'hf));
        wait_drained();

        for (ph = 0; ph < NUM_SETTINGS; ph++) begin
            if (ph >= 6) begin
                send_gap_pct = 0;
                take_gap_pct = 0;
            end else if (ph >= 3) begin
                send_gap_pct = 69;
                take_gap_pct = 8;
            end
            if (ph != 0) begin
                write_reg(tcd_pkg::CFG_REPEAT_LIMIT, 8'(limit_plan[ph]));
                write_reg(tcd_pkg::CFG_MAX_DELTA, 8'(delta_plan[ph]));
            end
            for (int i = 0; i < PKTS_PER_SETTING; i++) begin
                packets_to_send.push_back(random_packet());
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("Checked %0d results over %0d register settings.",
                 results_checked, NUM_SETTINGS);
        $display("%0d results resent the ECN status, %0d saw a random IP-ID.",
                 resent_count, random_id_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
